/* src/acnd_pkg.sv */
`timescale 1ns / 1ps

package acnd_pkg;

  // Frame store geometry
  localparam int MAX_SAMPLES = 4096;
  localparam int SAMPLE_W    = 16;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

  // Key and lag table
  localparam int KEY_W     = 6;
  localparam int KEY_COUNT = 26;
  localparam int FIRST_KEY = 27;
  localparam int KIDX_W    = 5;
  localparam int LAG_W     = 9;
  localparam int J_W       = (CNT_W > LAG_W) ? CNT_W : LAG_W;

  // Arithmetic widths
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int ACC_W    = PROD_W + ADDR_W;
  localparam int THR_W    = 16;
  localparam int SCALE_SH = 15;
  localparam int BEST_W   = ACC_W + THR_W;
  localparam int SPLIT    = ACC_W / 2;
  localparam int HI_W     = ACC_W - SPLIT;

  localparam logic signed [THR_W-1:0] THR_RESET = 16'sd16384;

  typedef logic [CNT_W-1:0] frame_len_t;

  // Write beat from the loader into the frame store
  typedef struct packed {
    logic                       en;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] data;
  } mem_wr_t;

  // Engine status seen by the loader
  typedef struct packed {
    logic busy;
  } eng_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_REDUCE,
    B_RUN,
    B_DRAIN,
    B_EVAL,
    B_SCALE1,
    B_SCALE2,
    B_OUT
  } back_state_t;

  // Period in samples at 44.1 kHz for keys 27 upwards
  function automatic logic [LAG_W-1:0] lag_of(input logic [KIDX_W-1:0] k);
    logic [LAG_W-1:0] lag;
    case (k)
      5'd0:    lag = 9'd357;
      5'd1:    lag = 9'd337;
      5'd2:    lag = 9'd318;
      5'd3:    lag = 9'd300;
      5'd4:    lag = 9'd283;
      5'd5:    lag = 9'd268;
      5'd6:    lag = 9'd253;
      5'd7:    lag = 9'd238;
      5'd8:    lag = 9'd225;
      5'd9:    lag = 9'd212;
      5'd10:   lag = 9'd200;
      5'd11:   lag = 9'd189;
      5'd12:   lag = 9'd179;
      5'd13:   lag = 9'd169;
      5'd14:   lag = 9'd159;
      5'd15:   lag = 9'd150;
      5'd16:   lag = 9'd142;
      5'd17:   lag = 9'd134;
      5'd18:   lag = 9'd126;
      5'd19:   lag = 9'd119;
      5'd20:   lag = 9'd113;
      5'd21:   lag = 9'd106;
      5'd22:   lag = 9'd100;
      5'd23:   lag = 9'd95;
      5'd24:   lag = 9'd89;
      5'd25:   lag = 9'd84;
      default: lag = '0;
    endcase
    return lag;
  endfunction

endpackage

/* src/acnd_ifs.sv */
`timescale 1ns / 1ps

interface acnd_in_if;
  import acnd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_sample;
  modport source(output valid, sample, last_sample, input ready);
  modport sink(input valid, sample, last_sample, output ready);
endinterface

interface acnd_out_if;
  import acnd_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] note_key;
  modport source(output valid, note_key, input ready);
  modport sink(input valid, note_key, output ready);
endinterface

/* src/acnd_front.sv */
`timescale 1ns / 1ps

module acnd_front (
  input  logic                 clk,
  input  logic                 rst,
  acnd_in_if.sink              samples,
  input  acnd_pkg::eng_status_t status,
  input  logic                 q_nonempty,
  output acnd_pkg::mem_wr_t    wr,
  output logic                 q_push,
  output acnd_pkg::frame_len_t q_data
);
  import acnd_pkg::*;

  frame_len_t count;
  frame_len_t count_next;
  logic       accept;
  logic       room;

  // Hold the loader while a frame is queued or under analysis
  assign samples.ready = !status.busy && !q_nonempty;
  assign accept        = samples.valid && samples.ready;
  assign room          = count < CNT_W'(MAX_SAMPLES);

  // Write the beat into the frame store; drop it once the store is full
  assign wr.en   = accept && room;
  assign wr.addr = count[ADDR_W-1:0];
  assign wr.data = samples.sample;

  // Hand the finished frame length to the engine
  assign q_push = accept && samples.last_sample;
  assign q_data = room ? count + CNT_W'(1) : count;

  always_comb begin
    count_next = count;
    if (accept) begin
      if (samples.last_sample) begin
        count_next = '0;
      end else if (room) begin
        count_next = count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

/* src/acnd_queue.sv */
`timescale 1ns / 1ps

module acnd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  acnd_pkg::frame_len_t push_data,
  input  logic                 pop,
  output logic                 nonempty,
  output logic                 full,
  output acnd_pkg::frame_len_t head
);
  import acnd_pkg::*;

  frame_len_t  slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        do_push;
  logic        do_pop;

  assign nonempty = fill != 2'd0;
  assign full     = fill == 2'd2;
  assign head     = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  // Store the pushed frame length
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

/* src/acnd_back.sv */
`timescale 1ns / 1ps

module acnd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic signed [15:0]         cfg_wdata,
  input  acnd_pkg::mem_wr_t          wr,
  input  logic                       q_nonempty,
  input  acnd_pkg::frame_len_t       q_head,
  output logic                       q_pop,
  output acnd_pkg::eng_status_t      status,
  acnd_out_if.source                 notes
);
  import acnd_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];

  logic signed [THR_W-1:0]          threshold;
  frame_len_t                       n;
  logic [ADDR_W-1:0]                i;
  logic [J_W-1:0]                   j;
  logic [KIDX_W-1:0]                k;
  logic                             energy_pass;
  logic signed [SAMPLE_W-1:0]       rd_a;
  logic signed [SAMPLE_W-1:0]       rd_b;
  logic                             v_rd;
  logic                             v_mul;
  logic signed [PROD_W-1:0]         prod;
  logic signed [ACC_W-1:0]          acc;
  logic [ACC_W-1:0]                 energy;
  logic signed [THR_W+SPLIT:0]      p_lo;
  logic signed [THR_W+HI_W:0]       p_hi;
  logic signed [BEST_W-1:0]         best;
  logic [KEY_W-1:0]                 best_key;
  logic                             out_valid;
  logic [KEY_W-1:0]                 out_key;

  logic                             issue;
  logic                             load_out;
  logic                             out_free;
  logic                             last_issue;
  logic                             reduce_done;
  logic                             last_key;
  logic                             better;
  logic [J_W-1:0]                   j_inc;
  logic [J_W-1:0]                   j_step;
  logic signed [BEST_W-1:0]         scaled;

  // Lag and index bookkeeping
  assign last_issue  = CNT_W'(i) == n - CNT_W'(1);
  assign reduce_done = j < J_W'(n);
  assign j_inc       = j + J_W'(1);
  assign j_step      = (j_inc == J_W'(n)) ? '0 : j_inc;
  assign last_key    = k == KIDX_W'(KEY_COUNT - 1);

  // Score C * 2^15 against the running best
  assign scaled   = $signed({(ACC_W + 1)'(acc), {SCALE_SH{1'b0}}});
  assign better   = scaled > best;
  assign out_free = !out_valid || notes.ready;

  assign notes.valid    = out_valid;
  assign notes.note_key = out_key;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:   if (q_nonempty) state_next = B_REDUCE;
      B_REDUCE: if (reduce_done) state_next = B_RUN;
      B_RUN:    if (last_issue) state_next = B_DRAIN;
      B_DRAIN:  if (!v_rd && !v_mul) state_next = B_EVAL;
      B_EVAL: begin
        if (energy_pass) begin
          state_next = (acc == '0) ? B_OUT : B_SCALE1;
        end else begin
          state_next = last_key ? B_OUT : B_REDUCE;
        end
      end
      B_SCALE1: state_next = B_SCALE2;
      B_SCALE2: state_next = B_REDUCE;
      B_OUT:    if (out_free) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop       = (state == B_IDLE) && q_nonempty;
    issue       = state == B_RUN;
    load_out    = (state == B_OUT) && out_free;
    status.busy = (state != B_IDLE) && (state != B_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Frame store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (issue) begin
      rd_a <= mem[i];
      rd_b <= mem[j[ADDR_W-1:0]];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
      v_rd      <= 1'b0;
      v_mul     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      v_rd  <= issue;
      v_mul <= v_rd;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (notes.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    prod <= rd_a * rd_b;
    if (state == B_REDUCE && reduce_done) begin
      acc <= '0;
    end else if (v_mul) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Sequencing over energy pass and key lags
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_key <= best_key;
    end
    unique case (state)
      B_IDLE: begin
        if (q_nonempty) begin
          n           <= q_head;
          j           <= '0;
          k           <= '0;
          energy_pass <= 1'b1;
          best_key    <= '0;
        end
      end
      B_REDUCE: begin
        if (reduce_done) begin
          i <= '0;
        end else begin
          j <= j - J_W'(n);
        end
      end
      B_RUN: begin
        i <= i + ADDR_W'(1);
        j <= j_step;
      end
      B_EVAL: begin
        if (energy_pass) begin
          energy      <= acc;
          energy_pass <= 1'b0;
        end else begin
          if (better) begin
            best     <= scaled;
            best_key <= KEY_W'(FIRST_KEY) + KEY_W'(k);
          end
          if (!last_key) begin
            k <= k + KIDX_W'(1);
            j <= J_W'(lag_of(k + KIDX_W'(1)));
          end
        end
      end
      B_SCALE1: begin
        // Split threshold * energy into two narrow products
        p_lo <= threshold * $signed({1'b0, energy[SPLIT-1:0]});
        p_hi <= threshold * $signed({1'b0, energy[ACC_W-1:SPLIT]});
      end
      B_SCALE2: begin
        best <= (BEST_W'(p_hi) << SPLIT) + BEST_W'(p_lo);
        j    <= J_W'(lag_of(k));
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/autocorrelation_note_detector_unit.sv */
`timescale 1ns / 1ps

// Pitch detector for frames of signed 16-bit samples at 44.1 kHz. Samples load
// at one beat per cycle into a 4096-entry frame store; a beat with last_sample
// set closes the frame and yields exactly one note_key beat (key 27..52, or 0
// when no key's normalised autocorrelation beats the threshold or the frame is
// silent). Samples past 4096 are dropped. Analysis runs one shared
// multiply-accumulate fed by the two read ports of the frame store, one product
// per cycle: an energy pass plus 26 lag passes, each over all n samples and
// followed by pipeline drain and scoring; on frames shorter than the lag, the lag
// is first folded below n by repeated subtraction. The loader stalls while a
// frame is analysed and resumes once scoring ends, even while the result still
// waits for the output register. No clearing pass is needed after reset. The
// threshold is a signed Q1.15 fraction of the energy, reset to 0.5, and may be
// written only while the block is idle.
module autocorrelation_note_detector_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic signed [15:0] cfg_wdata,
  acnd_in_if.sink            samples,
  acnd_out_if.source         notes
);
  import acnd_pkg::*;

  mem_wr_t     wr;
  eng_status_t status;
  logic        q_push;
  frame_len_t  q_data;
  logic        q_pop;
  logic        q_nonempty;
  logic        q_full;
  frame_len_t  q_head;

  acnd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .status    (status),
    .q_nonempty(q_nonempty),
    .wr        (wr),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  acnd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_data),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .full     (q_full),
    .head     (q_head)
  );

  acnd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .wr        (wr),
    .q_nonempty(q_nonempty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .status    (status),
    .notes     (notes)
  );

  // A closed frame never finds the queue full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("frame queued while queue full");

  // The loader stays stalled while the engine reads the frame store
  a_hold_loader: assert property (@(posedge clk) disable iff (rst)
    status.busy |-> !samples.ready)
    else $error("sample accepted during analysis");

  // A queued frame is held, with the loader stalled, until the engine takes it
  a_pop_follows: assert property (@(posedge clk) disable iff (rst)
    q_push |=> q_nonempty && !samples.ready)
    else $error("queued frame lost");

  // Engine pops only a queued frame
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_nonempty && !samples.ready)
    else $error("pop without queued frame");

endmodule
